// ----- rtl/avr_pkg.sv -----
// Shared types, constants and tables of the axis-angle vector rotator.
`default_nettype none
package avr_pkg;

	localparam int COORD_WIDTH      = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COEF_W           = 18;
	localparam int CFG_IDX_W        = 8;
	localparam int CFG_DATA_W       = 16;
	localparam int IN_DEPTH         = 2;
	localparam int OUT_DEPTH        = 4;
	localparam int ATAB_LEN         = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 8'd3;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t COEF_ONE  = 18'sd32768;
	localparam coef_t COEF_ZERO = 18'sd0;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vec_x;
		logic signed [COORD_WIDTH-1:0] vec_y;
		logic signed [COORD_WIDTH-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rot_x;
		logic signed [COORD_WIDTH-1:0] rot_y;
		logic signed [COORD_WIDTH-1:0] rot_z;
	} rot_t;

	typedef struct packed {
		logic          busy;
		coef_t [8:0]   coef;
	} mtx_status_t;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ANGLE_TAB [ATAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

endpackage
`default_nettype wire

// ----- rtl/avr_fifo.sv -----
// Small register queue with occupancy count.
`default_nettype none
module avr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/avr_matrix.sv -----
// Register file, CORDIC sequencer and rotation matrix builder.
`default_nettype none
module avr_matrix import avr_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output mtx_status_t                status
);
	localparam int STEP_W = $clog2(CORDIC_STEPS+1);
	localparam int CW     = 34;
	localparam int Q43_W  = 54;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_CORD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_PROD  = 3'd4;
	localparam logic [2:0] ST_TERM  = 3'd5;
	localparam logic [2:0] ST_COEF  = 3'd6;

	logic [2:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic [15:0]             angle_q;
	logic signed [15:0]      ax_q, ay_q, az_q;
	logic signed [CW-1:0]    x_q, y_q, z_q;
	logic                    flip_q;
	coef_t                   cq_q, sq_q;
	logic signed [31:0]      uxx_q, uyy_q, uzz_q, uxy_q, uxz_q, uyz_q;
	logic signed [33:0]      sx_q, sy_q, sz_q;
	logic signed [18:0]      omc_q;
	logic signed [Q43_W-1:0] dx_q, dy_q, dz_q, oxy_q, oxz_q, oyz_q;
	coef_t [8:0]             coef_q;

	logic                    wr, start;
	logic [15:0]             a_sum, a_alt;
	logic signed [CW-1:0]    sh_x, sh_y, tab, xr, yr;

	function automatic coef_t round_coef(input logic signed [Q43_W-1:0] v);
		logic signed [Q43_W-1:0] t;
		t = (v + Q43_W'(64'sd134217728)) >>> 28;
		if (t > Q43_W'(64'sd131071)) begin
			return 18'sd131071;
		end else if (t < -Q43_W'(64'sd131072)) begin
			return -18'sd131072;
		end
		return t[COEF_W-1:0];
	endfunction

	function automatic logic signed [Q43_W-1:0] diag(input logic signed [31:0] uu,
		input coef_t c);
		logic signed [32:0] rest;
		rest = 33'sd268435456 - 33'(uu);
		return (Q43_W'(uu) <<< 15) + Q43_W'(c) * Q43_W'(rest);
	endfunction

	assign cfg_ready   = (state_q == ST_IDLE);
	assign wr          = cfg_valid && cfg_ready;
	assign start       = wr && (cfg_index <= REG_AXIS_Z);
	assign status.busy = (state_q != ST_IDLE);
	assign status.coef = coef_q;

	assign a_sum = angle_q + 16'd16384;
	assign a_alt = angle_q + 16'd32768;
	assign sh_x  = x_q >>> step_q;
	assign sh_y  = y_q >>> step_q;
	assign tab   = CW'(ANGLE_TAB[5'(step_q)]);
	assign xr    = (x_q + CW'(16384)) >>> 15;
	assign yr    = (y_q + CW'(16384)) >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			angle_q <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			az_q    <= 16'sd16384;
			for (int k = 0; k < 9; k++) begin
				coef_q[k] <= (k % 4 == 0) ? COEF_ONE : COEF_ZERO;
			end
		end else begin
			if (wr) begin
				case (cfg_index)
					REG_ANGLE:  angle_q <= cfg_data;
					REG_AXIS_X: ax_q    <= cfg_data;
					REG_AXIS_Y: ay_q    <= cfg_data;
					REG_AXIS_Z: az_q    <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= (angle_q == '0) ? ST_PROD : ST_CORD;
				end
				ST_CORD: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS-1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_TERM;
				ST_TERM:  state_q <= ST_COEF;
				ST_COEF: begin
					state_q   <= ST_IDLE;
					coef_q[0] <= round_coef(dx_q);
					coef_q[1] <= round_coef(oxy_q - (Q43_W'(sz_q) <<< 14));
					coef_q[2] <= round_coef(oxz_q + (Q43_W'(sy_q) <<< 14));
					coef_q[3] <= round_coef(oxy_q + (Q43_W'(sz_q) <<< 14));
					coef_q[4] <= round_coef(dy_q);
					coef_q[5] <= round_coef(oyz_q - (Q43_W'(sx_q) <<< 14));
					coef_q[6] <= round_coef(oxz_q - (Q43_W'(sy_q) <<< 14));
					coef_q[7] <= round_coef(oyz_q + (Q43_W'(sx_q) <<< 14));
					coef_q[8] <= round_coef(dz_q);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT: begin
				cq_q   <= COEF_ONE;
				sq_q   <= COEF_ZERO;
				flip_q <= a_sum[15];
				x_q    <= CW'(64'sd652032874);
				y_q    <= '0;
				z_q    <= CW'($signed(a_sum[15] ? a_alt : angle_q)) <<< 16;
			end
			ST_CORD: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - sh_y;
					y_q <= y_q + sh_x;
					z_q <= z_q - tab;
				end else begin
					x_q <= x_q + sh_y;
					y_q <= y_q - sh_x;
					z_q <= z_q + tab;
				end
			end
			ST_ROUND: begin
				cq_q <= flip_q ? -xr[COEF_W-1:0] : xr[COEF_W-1:0];
				sq_q <= flip_q ? -yr[COEF_W-1:0] : yr[COEF_W-1:0];
			end
			ST_PROD: begin
				uxx_q <= ax_q * ax_q;
				uyy_q <= ay_q * ay_q;
				uzz_q <= az_q * az_q;
				uxy_q <= ax_q * ay_q;
				uxz_q <= ax_q * az_q;
				uyz_q <= ay_q * az_q;
				sx_q  <= ax_q * sq_q;
				sy_q  <= ay_q * sq_q;
				sz_q  <= az_q * sq_q;
				omc_q <= 19'sd32768 - 19'(cq_q);
			end
			ST_TERM: begin
				dx_q  <= diag(uxx_q, cq_q);
				dy_q  <= diag(uyy_q, cq_q);
				dz_q  <= diag(uzz_q, cq_q);
				oxy_q <= Q43_W'(uxy_q) * Q43_W'(omc_q);
				oxz_q <= Q43_W'(uxz_q) * Q43_W'(omc_q);
				oyz_q <= Q43_W'(uyz_q) * Q43_W'(omc_q);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/avr_datapath.sv -----
// Two-stage matrix-vector multiply with rounding and saturation.
`default_nettype none
module avr_datapath import avr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  issue,
	input  wire vec_t  vec,
	input  wire coef_t [8:0] coef,
	output logic [1:0] inflight,
	output logic       valid,
	output rot_t       rot
);
	localparam int PROD_W = COEF_W + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'((64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;

	logic signed [PROD_W-1:0]      prod_s1 [9];
	logic                          valid_s1, valid_s2;
	logic signed [COORD_WIDTH-1:0] res_s2 [3];
	logic signed [COORD_WIDTH-1:0] v [3];
	logic signed [SUM_W-1:0]       acc [3];

	assign v[0] = vec.vec_x;
	assign v[1] = vec.vec_y;
	assign v[2] = vec.vec_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = (SUM_W'(prod_s1[3*i]) + SUM_W'(prod_s1[3*i+1]) + SUM_W'(prod_s1[3*i+2])
				+ SUM_W'(16384)) >>> 15;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			prod_s1[k] <= coef[k] * v[k % 3];
		end
		for (int i = 0; i < 3; i++) begin
			if (acc[i] > RES_MAX) begin
				res_s2[i] <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end else if (acc[i] < RES_MIN) begin
				res_s2[i] <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
			end else begin
				res_s2[i] <= acc[i][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign inflight  = {1'b0, valid_s1} + {1'b0, valid_s2};
	assign valid     = valid_s2;
	assign rot.rot_x = res_s2[0];
	assign rot.rot_y = res_s2[1];
	assign rot.rot_z = res_s2[2];
endmodule
`default_nettype wire

// ----- rtl/axis_angle_vector_rotator_core.sv -----
// Top level of the axis-angle vector rotator.
`default_nettype none
// Rotates a stream of Q8.16 vectors about a unit axis (Q1.14) by an angle in
// binary units (65536 per turn). Vectors are pushed into a short input queue,
// multiplied by the held 3x3 matrix in a two-stage pipeline and transferred out
// through a four-entry result queue: one vector per clock sustained while the
// result queue has room and no rebuild runs. A register write with index 0..3
// rebuilds the matrix: CORDIC iterations, rounding, products, terms and the
// coefficients in turn (CORDIC and rounding are skipped when the angle is zero);
// cfg_ready is low and no vector enters the pipeline meanwhile. Writes to other
// indexes are dropped. Reset gives the identity matrix.
module axis_angle_vector_rotator_core import avr_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire vec_t                  vec,
	output logic                       empty,
	input  wire logic                  pop,
	output rot_t                       rot,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

	mtx_status_t                status;
	vec_t                       front_vec;
	logic                       front_empty;
	logic [$clog2(IN_DEPTH+1)-1:0] front_cnt;
	logic                       issue;
	logic [1:0]                 inflight;
	logic                       res_valid;
	rot_t                       res;
	logic                       res_full;
	logic [OUT_CNT_W-1:0]       res_cnt;

	avr_matrix #(.CORDIC_STEPS(CORDIC_STEPS)) u_matrix (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .status
	);

	// front: take vectors whatever the back end is doing
	avr_fifo #(.WIDTH($bits(vec_t)), .DEPTH(IN_DEPTH)) u_front (
		.clk, .arst_n,
		.push  (push),
		.wdata (vec),
		.full  (full),
		.pop   (issue),
		.rdata (front_vec),
		.empty (front_empty),
		.count (front_cnt)
	);

	// issue only with room reserved for every vector still in the pipeline,
	// and hold while the matrix is being rebuilt
	assign issue = !front_empty && !status.busy &&
		((OUT_CNT_W+1)'(res_cnt) + (OUT_CNT_W+1)'(inflight) < (OUT_CNT_W+1)'(OUT_DEPTH));

	avr_datapath u_datapath (
		.clk, .arst_n,
		.issue    (issue),
		.vec      (front_vec),
		.coef     (status.coef),
		.inflight (inflight),
		.valid    (res_valid),
		.rot      (res)
	);

	// back: result queue decouples the pipeline from the consumer
	avr_fifo #(.WIDTH($bits(rot_t)), .DEPTH(OUT_DEPTH)) u_back (
		.clk, .arst_n,
		.push  (res_valid),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (rot),
		.empty (empty),
		.count (res_cnt)
	);

	a_no_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !status.busy)
		else $error("vector issued during matrix rebuild");

	a_rebuild_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index <= REG_AXIS_Z) |=> status.busy)
		else $error("register write did not start a rebuild");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_full)
		else $error("result pushed into full queue");

	a_front_count: assert property (@(posedge clk) disable iff (!arst_n)
		front_cnt <= ($clog2(IN_DEPTH+1))'(IN_DEPTH))
		else $error("front queue count out of range");
endmodule
`default_nettype wire

// ----- dv/axis_angle_vector_rotator_scoreboard.sv -----
// Scoreboard for the axis-angle vector rotator: matrix predictor and result check.
`default_nettype none
module axis_angle_vector_rotator_scoreboard import avr_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  full,
	input  wire vec_t                  vec,
	input  wire logic                  empty,
	input  wire logic                  pop,
	input  wire rot_t                  rot,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] angle_reg, ax_reg, ay_reg, az_reg;
	longint      mtx [9];
	rot_t        rotated_q [$];

	function automatic longint q43_to_coef(longint v);
		longint r;
		r = (v + (64'sd1 <<< 27)) >>> 28;
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r;
	endfunction

	task automatic rebuild_matrix();
		longint cq, sq, x, y, z, dx, dy, ux, uy, uz, omc, one28;
		longint sx, sy, sz, xy, xz, yz;
		logic [15:0] a;
		bit flip;
		cq = 32768;
		sq = 0;
		a = angle_reg;
		if (a != 0) begin
			flip = 17'(a + 17'd16384) % 65536 >= 32768;
			if (flip) a = a + 16'd32768;
			z = (a >= 32768 ? longint'(a) - 65536 : longint'(a)) * 65536;
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS && i < ATAB_LEN; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ANGLE_TAB[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ANGLE_TAB[i]);
				end
			end
			cq = (x + 16384) >>> 15;
			sq = (y + 16384) >>> 15;
			if (flip) begin
				cq = -cq;
				sq = -sq;
			end
		end
		ux = longint'($signed(ax_reg));
		uy = longint'($signed(ay_reg));
		uz = longint'($signed(az_reg));
		omc = 32768 - cq;
		one28 = 64'sd1 <<< 28;
		sx = ux * sq * 16384; sy = uy * sq * 16384; sz = uz * sq * 16384;
		xy = ux * uy * omc; xz = ux * uz * omc; yz = uy * uz * omc;
		mtx[0] = q43_to_coef(ux * ux * 32768 + cq * (one28 - ux * ux));
		mtx[1] = q43_to_coef(xy - sz);
		mtx[2] = q43_to_coef(xz + sy);
		mtx[3] = q43_to_coef(xy + sz);
		mtx[4] = q43_to_coef(uy * uy * 32768 + cq * (one28 - uy * uy));
		mtx[5] = q43_to_coef(yz - sx);
		mtx[6] = q43_to_coef(xz - sy);
		mtx[7] = q43_to_coef(yz + sx);
		mtx[8] = q43_to_coef(uz * uz * 32768 + cq * (one28 - uz * uz));
	endtask

	function automatic rot_t rotate_vector(vec_t v);
		longint vin [3], vh [3], vl [3];
		longint hi, lo, r, lim;
		logic signed [COORD_WIDTH-1:0] res [3];
		vin[0] = longint'(v.vec_x);
		vin[1] = longint'(v.vec_y);
		vin[2] = longint'(v.vec_z);
		lim = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		for (int j = 0; j < 3; j++) begin
			vh[j] = vin[j] >>> 16;
			vl[j] = vin[j] - vh[j] * 65536;
		end
		for (int i = 0; i < 3; i++) begin
			hi = 0;
			lo = 0;
			for (int j = 0; j < 3; j++) begin
				hi += mtx[3*i+j] * vh[j];
				lo += mtx[3*i+j] * vl[j];
			end
			r = hi * 2 + ((lo + 16384) >>> 15);
			if (r > lim) r = lim;
			if (r < -lim - 1) r = -lim - 1;
			res[i] = r[COORD_WIDTH-1:0];
		end
		return '{rot_x: res[0], rot_y: res[1], rot_z: res[2]};
	endfunction

	assign pending = rotated_q.size();

	always @(posedge clk or negedge arst_n) begin
		rot_t want;
		if (!arst_n) begin
			angle_reg = 16'd0;
			ax_reg = 16'd0;
			ay_reg = 16'd0;
			az_reg = 16'd16384;
			rebuild_matrix();
			rotated_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ANGLE:  begin angle_reg = cfg_data; rebuild_matrix(); end
					REG_AXIS_X: begin ax_reg = cfg_data; rebuild_matrix(); end
					REG_AXIS_Y: begin ay_reg = cfg_data; rebuild_matrix(); end
					REG_AXIS_Z: begin az_reg = cfg_data; rebuild_matrix(); end
					default: ;
				endcase
			end
			if (push && !full)
				rotated_q.push_back(rotate_vector(vec));
			if (pop && !empty) begin
				if (rotated_q.size() == 0) begin
					$error("result with nothing expected: %p", rot);
					fail_count++;
				end else begin
					want = rotated_q.pop_front();
					if (rot.rot_x !== want.rot_x) begin
						$error("rot_x expected %0d actual %0d", want.rot_x, rot.rot_x);
						fail_count++;
					end
					if (rot.rot_y !== want.rot_y) begin
						$error("rot_y expected %0d actual %0d", want.rot_y, rot.rot_y);
						fail_count++;
					end
					if (rot.rot_z !== want.rot_z) begin
						$error("rot_z expected %0d actual %0d", want.rot_z, rot.rot_z);
						fail_count++;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- dv/axis_angle_vector_rotator_core_test.sv -----
// Testbench top of the axis-angle vector rotator: stimulus, pacing and verdict.
`default_nettype none
module axis_angle_vector_rotator_core_test;
	import avr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// index outside the register map: the block must drop the write
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;
	localparam int STALL_LIMIT = 20000;
	localparam int LATENCY = 16;

	logic                  clk, arst_n;
	logic                  push, full, empty, pop;
	vec_t                  vec;
	rot_t                  rot;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count, pending;
	int                    send_idle_pct, recv_idle_pct;
	int                    quiet_cycles;

	axis_angle_vector_rotator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .vec(vec),
		.empty(empty), .pop(pop), .rot(rot),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	axis_angle_vector_rotator_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .vec(vec),
		.empty(empty), .pop(pop), .rot(rot),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: stall pop at random according to the current receiver idle rate.
	initial pop = 1'b0;
	always @(negedge clk)
		pop <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog: count cycles with no transfer on any channel.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Hold push high across back-to-back transfers; lower it only while idling.
	task automatic send_vector(vec_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		vec <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drain every expected result before touching the registers.
	task automatic settle();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic set_rotation(logic [15:0] ang, logic [15:0] ux, logic [15:0] uy,
			logic [15:0] uz);
		settle();
		write_reg(REG_AXIS_X, ux);
		write_reg(REG_AXIS_Y, uy);
		write_reg(REG_AXIS_Z, uz);
		write_reg(REG_ANGLE, ang);
	endtask

	function automatic logic [15:0] axis_component();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] coordinate();
		case ($urandom_range(5))
			0: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
			1: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
			2: return COORD_WIDTH'($signed($urandom_range(2048)) - 1024);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	initial begin
		vec_t v;
		logic signed [COORD_WIDTH-1:0] vmax, vmin;
		arst_n = 1'b0;
		push = 1'b0;
		vec = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 35;
		recv_idle_pct = 82;
		vmax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		vmin = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset identity, extremes of the coordinates.
		send_vector('{vec_x: vmax, vec_y: vmin, vec_z: '0});
		send_vector('{vec_x: vmin, vec_y: vmax, vec_z: vmax});
		send_vector('{vec_x: 24'sd65536, vec_y: -24'sd1, vec_z: 24'sd1});
		// Angle zero with a tilted axis still gives the identity.
		set_rotation(16'd0, 16'h2000, 16'hE000, 16'h2D41);
		send_vector('{vec_x: vmax, vec_y: vmin, vec_z: 24'sd12345});
		// Quarter, half and three-quarter turns about z; the turn boundaries flip.
		set_rotation(16'd16384, 16'd0, 16'd0, 16'd16384);
		send_vector('{vec_x: vmax, vec_y: vmin, vec_z: vmax});
		settle();
		write_reg(REG_ANGLE, 16'd32768);
		send_vector('{vec_x: vmax, vec_y: vmin, vec_z: vmin});
		settle();
		write_reg(REG_ANGLE, 16'd49152);
		send_vector('{vec_x: 24'sd65536, vec_y: 24'sd65536, vec_z: 24'sd65536});
		settle();
		write_reg(REG_ANGLE, 16'hFFFF);
		send_vector('{vec_x: vmax, vec_y: vmax, vec_z: vmax});
		// Out-of-range index: dropped, matrix kept.
		settle();
		write_reg(REG_NONE, 16'hFFFF);
		send_vector('{vec_x: vmin, vec_y: vmin, vec_z: vmin});
		// Axis far from unit length: coefficients grow beyond one, outputs overflow.
		set_rotation(16'd21000, 16'hC000, 16'h4000, 16'hC000);
		send_vector('{vec_x: vmax, vec_y: vmin, vec_z: vmax});
		send_vector('{vec_x: vmin, vec_y: vmax, vec_z: vmin});
		set_rotation(16'd8192, 16'h4000, 16'h4000, 16'h4000);
		send_vector('{vec_x: vmax, vec_y: vmax, vec_z: vmax});

		// Random: three pacing phases, a fresh rotation every 70 vectors.
		for (int n = 0; n < 1050; n++) begin
			if (n == 350) begin
				send_idle_pct = 82;
				recv_idle_pct = 35;
			end else if (n == 700) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n % 70 == 0) begin
				set_rotation(16'($urandom), axis_component(), axis_component(),
					axis_component());
				if ($urandom_range(3) == 0)
					write_reg(CFG_IDX_W'($urandom_range(255, 4)), 16'($urandom));
			end
			v.vec_x = coordinate();
			v.vec_y = coordinate();
			v.vec_z = coordinate();
			send_vector(v);
		end
		push <= 1'b0;

		// Drain, allow the pipeline to flush, then decide.
		while (pending != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
